### sv/fssd_pkg.sv
// shared types, constants and the segment decoder for the serial display driver
// no dependencies

package fssd_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned MagWidth   = 14;
  localparam int unsigned FrameBits  = 64;
  localparam int unsigned CntWidth   = $clog2(FrameBits);

  localparam logic [MagWidth-1:0] MaxShown = 14'd9999;
  // floor(v / 10) == (v * Recip10) >> RecipShift for every v up to 9999
  localparam logic [12:0] Recip10    = 13'd6554;
  localparam int unsigned RecipShift = 16;

  localparam logic [7:0] SegBlank = 8'hFF;

  typedef logic [NumDigits-1:0][7:0] frame_t;

  typedef struct packed {
    logic   push;
    frame_t frame;
  } push_t;

  typedef struct packed {
    logic   avail;
    frame_t frame;
  } head_t;

  // active-low segment byte of a decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = SegBlank;
    endcase
    return code;
  endfunction

endpackage

### sv/fssd_if.sv
// valid/ready channel interfaces for the display driver
// depends on fssd_pkg

interface fssd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fssd_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fssd_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_after;
  logic last;

  modport source (output valid, output serial_bit, output latch_after, output last,
                  input ready);
  modport sink   (input valid, input serial_bit, input latch_after, input last,
                  output ready);
endinterface

### sv/four_digit_seven_segment_serial_driver_core.sv
// top level of the four-digit seven-segment serial driver
// depends on fssd_pkg, fssd_if, fssd_front, fssd_queue and fssd_back

// Takes one signed 16-bit number per input beat and produces a 64-beat serial
// frame for a common-anode four-digit display driven through two chained
// shift registers. The number is clamped to 0..9999 (negatives show "0"),
// split into digits and leading zeros of the upper three digits are blanked.
// Digits go out units first; each digit is 16 beats, msb first: the active-low
// segment byte, then the one-hot digit select byte. latch_after marks the
// sixteenth beat of every digit and last marks the 64th beat of the frame.
// The shifter emits one bit per cycle while the sink is ready, which sets the
// sustained rate. The front end clamps and accepts a number, then makes one
// digit per cycle through a reciprocal multiply, and hands finished frames
// to a two-frame queue, so while the queue has room it takes new numbers
// while the shifter is busy and while a result beat is held by a stalled sink.
// A number reaches out_o via v_q, dig_q, the queue and the output register.

module four_digit_seven_segment_serial_driver_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fssd_in_if.sink    in_i,
  fssd_out_if.source out_o
);

  fssd_pkg::push_t push;
  fssd_pkg::head_t head;
  logic            room;
  logic            pop;

  // number to digits to segment bytes
  fssd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  // decouples conversion from shifting
  fssd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .head_o (head),
    .pop_i  (pop)
  );

  // one bit per beat into the output register
  fssd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_last_on_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> out_o.latch_after)
    else $error("last beat must carry latch");
`endif

endmodule

### sv/fssd_front.sv
// front end: clamps the number, splits it into digits, blanks leading zeros
// depends on fssd_pkg and fssd_if

module fssd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  fssd_in_if.sink           in_i,
  input  logic              room_i,
  output fssd_pkg::push_t   push_o
);

  logic [fssd_pkg::MagWidth-1:0] v_q, v_d, clamp_val;
  logic [2:0]                    cnt_q;
  logic                          busy_q;
  logic [fssd_pkg::NumDigits-1:0][3:0] dig_q;

  logic [fssd_pkg::MagWidth+12:0] prod;
  logic [fssd_pkg::MagWidth-1:0]  quot, quot_x10;
  logic [3:0]                     digit;
  logic                           done, push, accept;
  fssd_pkg::frame_t               frame;

  // clamp to 0..9999
  always_comb begin
    if (in_i.value[fssd_pkg::ValueWidth-1]) begin
      clamp_val = '0;
    end else if (in_i.value[fssd_pkg::ValueWidth-2:0] > 15'(fssd_pkg::MaxShown)) begin
      clamp_val = fssd_pkg::MaxShown;
    end else begin
      clamp_val = in_i.value[fssd_pkg::MagWidth-1:0];
    end
  end

  // one digit per cycle by reciprocal multiply, units first
  assign prod     = v_q * fssd_pkg::Recip10;
  assign quot     = fssd_pkg::MagWidth'(prod >> fssd_pkg::RecipShift);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit    = v_q[3:0] - quot_x10[3:0];
  assign v_d      = quot;

  assign done   = busy_q && cnt_q[2];
  assign push   = done && room_i;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_q || push;

  // leading-zero blanking, units always shown
  always_comb begin
    frame[0] = fssd_pkg::seg_code(dig_q[0]);
    frame[1] = fssd_pkg::seg_code(dig_q[1]);
    frame[2] = fssd_pkg::seg_code(dig_q[2]);
    frame[3] = fssd_pkg::seg_code(dig_q[3]);
    if (dig_q[3] == 4'd0) begin
      frame[3] = fssd_pkg::SegBlank;
      if (dig_q[2] == 4'd0) begin
        frame[2] = fssd_pkg::SegBlank;
        if (dig_q[1] == 4'd0) begin
          frame[1] = fssd_pkg::SegBlank;
        end
      end
    end
  end

  assign push_o.push  = push;
  assign push_o.frame = frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (push) begin
      busy_q <= 1'b0;
    end else if (busy_q && !cnt_q[2]) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q <= clamp_val;
    end else if (busy_q && !cnt_q[2]) begin
      v_q              <= v_d;
      dig_q[cnt_q[1:0]] <= digit;
    end
  end

`ifndef SYNTHESIS
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !cnt_q[2]) |-> (digit < 4'd10))
    else $error("digit out of range");
`endif

endmodule

### sv/fssd_queue.sv
// two-entry frame queue between the front end and the shifter
// depends on fssd_pkg

module fssd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fssd_pkg::push_t  push_i,
  output logic             room_o,
  output fssd_pkg::head_t  head_o,
  input  logic             pop_i
);

  fssd_pkg::frame_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       count_q;

  assign room_o       = (count_q != 2'd2);
  assign head_o.avail = (count_q != 2'd0);
  assign head_o.frame = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (push_i.push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i.push, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_q] <= push_i.frame;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push |-> (count_q != 2'd2))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("pop from empty queue");
`endif

endmodule

### sv/fssd_back.sv
// back end: shifts each frame out one bit per beat with latch and end flags
// depends on fssd_pkg and fssd_if

module fssd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fssd_pkg::head_t  head_i,
  output logic             pop_o,
  fssd_out_if.source       out_o
);

  logic [fssd_pkg::CntWidth-1:0] bit_q;
  logic                          valid_q, sbit_q, latch_q, last_q;
  logic                          advance, sbit, latch, last;
  logic [1:0]                    dsel;
  logic [3:0]                    pos;
  logic [2:0]                    bidx;

  assign dsel = bit_q[5:4];
  assign pos  = bit_q[3:0];
  assign bidx = ~pos[2:0];   // msb first

  // first byte is the segment byte, second the one-hot digit select
  assign sbit  = pos[3] ? (bidx == {1'b0, dsel}) : head_i.frame[dsel][bidx];
  assign latch = (pos == 4'hF);
  assign last  = (bit_q == fssd_pkg::CntWidth'(fssd_pkg::FrameBits - 1));

  assign advance = !valid_q || out_o.ready;
  assign pop_o   = advance && head_i.avail && last;

  assign out_o.valid       = valid_q;
  assign out_o.serial_bit  = sbit_q;
  assign out_o.latch_after = latch_q;
  assign out_o.last        = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bit_q   <= '0;
    end else if (advance) begin
      valid_q <= head_i.avail;
      if (head_i.avail) begin
        bit_q <= bit_q + fssd_pkg::CntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && head_i.avail) begin
      sbit_q  <= sbit;
      latch_q <= latch;
      last_q  <= last;
    end
  end

`ifndef SYNTHESIS
  a_last_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> latch_q)
    else $error("frame end without latch");
  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (bit_q == '0))
    else $error("bit counter not at frame start after pop");
`endif

endmodule
